FILE: rtl/core/stack_machine_execute_unit_assert.svh
// Assertion macros for the stack machine execute unit.
// Used by smeu_back in this folder; expects clk and rst_n in scope.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMEU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMEU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/smeu_pkg.sv
// Shared types and codes for the stack machine execute unit.
// No dependencies; imported by every module of the unit except smeu_div.
package smeu_pkg;

  // Instruction modes as they arrive on the input channel.
  typedef enum logic [3:0] {
    MODE_PUSHC = 4'd0,
    MODE_ADD   = 4'd1,
    MODE_SUB   = 4'd2,
    MODE_MUL   = 4'd3,
    MODE_DIV   = 4'd4,
    MODE_MOD   = 4'd5,
    MODE_RDINT = 4'd6,
    MODE_WRINT = 4'd7,
    MODE_RDCHR = 4'd8,
    MODE_WRCHR = 4'd9,
    MODE_PUSHG = 4'd10,
    MODE_POPG  = 4'd11,
    MODE_ASF   = 4'd12,
    MODE_RSF   = 4'd13,
    MODE_PUSHL = 4'd14,
    MODE_POPL  = 4'd15
  } mode_t;

  // Instruction classes as seen by the back end.
  typedef enum logic [3:0] {
    CLS_PUSHV,
    CLS_ARITH,
    CLS_WRITE,
    CLS_PUSHG,
    CLS_POPG,
    CLS_ASF,
    CLS_RSF,
    CLS_PUSHL,
    CLS_POPL
  } cls_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_SKIP = 2'd1,
    STAT_OVFL = 2'd2
  } stat_t;

  // Console write kinds.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_CHR  = 2'd2
  } kind_t;

  // Decoded instruction carried through the queue.
  typedef struct packed {
    cls_t        cls;
    mode_t       mode;
    logic [23:0] opnd;
    logic [31:0] imm;
  } instr_t;

  localparam int QDEPTH = 2;

endpackage

FILE: rtl/core/smeu_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing; used by smeu_back for div and mod.
module smeu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quot,
  output logic [31:0] rem
);

  localparam int STEPS = 32;
  localparam int CNTW  = $clog2(STEPS);

  logic            busy_r, busy_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [31:0]     q_r, q_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     d_r;
  logic            negq_r, negr_r;
  logic [32:0]     shifted;
  logic [32:0]     diff;

  // Restoring step on magnitudes.
  always_comb begin
    shifted  = {rem_r, q_r[31]};
    diff     = shifted - {1'b0, d_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers load magnitudes and signs on start.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend[31] ? (32'd0 - dividend) : dividend;
      d_r    <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem_r  <= '0;
      negq_r <= dividend[31] ^ divisor[31];
      negr_r <= dividend[31];
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Truncating signs: quotient by both signs, remainder by the dividend.
  assign busy = busy_r;
  assign quot = negq_r ? (32'd0 - q_r) : q_r;
  assign rem  = negr_r ? (32'd0 - rem_r) : rem_r;

endmodule

FILE: rtl/core/smeu_queue.sv
// Short instruction queue between the front and back ends.
// Depends on smeu_pkg for the instruction type.
module smeu_queue
  import smeu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_stall,
  input  instr_t push_data,
  output logic   pop_valid,
  input  logic   pop_stall,
  output instr_t pop_data
);

  localparam int PW = $clog2(QDEPTH);

  instr_t          ent_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  logic            do_push, do_pop;

  assign push_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = ent_r[rp_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/smeu_front.sv
// Front end: accepts input transactions and classifies each instruction.
// Depends on smeu_pkg; feeds smeu_queue.
module smeu_front
  import smeu_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [23:0] in_operand,
  input  logic [31:0] in_read_value,
  input  logic        clearing,
  output logic        q_push_valid,
  input  logic        q_push_stall,
  output instr_t      q_push_data
);

  mode_t m;

  // Items are held off while memories are being cleared after reset.
  assign in_stall     = q_push_stall || clearing;
  assign q_push_valid = in_valid && !clearing;

  // Decode the mode into a class and form the value a push would store.
  always_comb begin
    m                = mode_t'(in_mode);
    q_push_data.mode = m;
    q_push_data.opnd = in_operand;
    q_push_data.imm  = {{8{in_operand[23]}}, in_operand};
    q_push_data.cls  = CLS_PUSHV;
    unique case (m) inside
      MODE_PUSHC: begin
        q_push_data.cls = CLS_PUSHV;
      end
      MODE_RDINT: begin
        q_push_data.cls = CLS_PUSHV;
        q_push_data.imm = in_read_value;
      end
      MODE_RDCHR: begin
        q_push_data.cls = CLS_PUSHV;
        q_push_data.imm = {{24{in_read_value[7]}}, in_read_value[7:0]};
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
        q_push_data.cls = CLS_ARITH;
      end
      MODE_WRINT, MODE_WRCHR: begin
        q_push_data.cls = CLS_WRITE;
      end
      MODE_PUSHG: q_push_data.cls = CLS_PUSHG;
      MODE_POPG:  q_push_data.cls = CLS_POPG;
      MODE_ASF:   q_push_data.cls = CLS_ASF;
      MODE_RSF:   q_push_data.cls = CLS_RSF;
      MODE_PUSHL: q_push_data.cls = CLS_PUSHL;
      MODE_POPL:  q_push_data.cls = CLS_POPL;
      default:    q_push_data.cls = CLS_PUSHV;
    endcase
  end

endmodule

FILE: rtl/core/smeu_back.sv
// Back end: operand stack and global memories, pointers, execution and result register.
// Depends on smeu_pkg, smeu_div and the assertion macro header.
`include "stack_machine_execute_unit_assert.svh"

module smeu_back
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH  = 256,
  parameter int GLOBAL_DEPTH = 64,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_stall,
  input  instr_t             q_data,
  output logic               clearing,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [1:0]         out_write_kind,
  output logic [31:0]        out_write_value,
  output logic [SPW-1:0]     out_stack_level,
  output logic [SPW-1:0]     out_frame_base
);

  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int GAW  = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
  localparam int MAXD = (STACK_DEPTH > GLOBAL_DEPTH) ? STACK_DEPTH : GLOBAL_DEPTH;
  localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int XW   = 26;

  typedef enum logic [3:0] {
    BS_CLEAR = 4'b0001,
    BS_IDLE  = 4'b0010,
    BS_EXEC  = 4'b0100,
    BS_DIV   = 4'b1000
  } bstate_t;

  bstate_t         state_r, state_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  logic [SPW-1:0]  sp_r, sp_nxt, fp_r, fp_nxt;
  logic [6:0]      gcfg_r;
  instr_t          ir_r;
  logic [31:0]     rd0_r, rd1_r, gd_r;
  logic            out_valid_r, out_valid_nxt;
  stat_t           status_r;
  kind_t           kind_r;
  logic [31:0]     wval_r;
  logic [SPW-1:0]  lvl_r, fb_r;

  logic [31:0]     stk_mem [STACK_DEPTH];
  logic [31:0]     glb_mem [GLOBAL_DEPTH];

  logic            take, out_free, commit, want_div, div_start, div_busy;
  logic [31:0]     div_q, div_r;
  logic [XW-1:0]   sp_x, fp_x, hd_opnd_x, ra0_x, ra1_x;
  logic [XW-1:0]   opnd_x, pos_x, gcnt_x, st_wa_x;
  logic            neg, full, g_bad, is_div;
  logic [31:0]     alu, res;
  stat_t           ex_status;
  kind_t           ex_kind;
  logic [31:0]     ex_wval, st_wd;
  logic [SPW-1:0]  ex_sp, ex_fp;
  logic            ex_st_we, ex_g_we, st_we, g_we;
  logic [AW-1:0]   st_wa;
  logic [GAW-1:0]  g_wa;
  logic [31:0]     g_wd;
  logic            clr_st, clr_g;

  assign clearing = (state_r == BS_CLEAR);
  assign q_stall  = (state_r != BS_IDLE);
  assign take     = q_valid && !q_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Read addresses for the instruction at the queue head.
  always_comb begin
    sp_x      = XW'(sp_r);
    fp_x      = XW'(fp_r);
    hd_opnd_x = {{(XW-24){q_data.opnd[23]}}, q_data.opnd};
    ra1_x     = sp_x - XW'(1);
    ra0_x     = '0;
    case (q_data.cls)
      CLS_ARITH: ra0_x = sp_x - XW'(2);
      CLS_RSF:   ra0_x = fp_x - XW'(1);
      CLS_PUSHL: ra0_x = fp_x + hd_opnd_x;
      default:   ra0_x = '0;
    endcase
  end

  // Guards and results for the instruction being executed.
  always_comb begin
    opnd_x = {{(XW-24){ir_r.opnd[23]}}, ir_r.opnd};
    neg    = ir_r.opnd[23];
    full   = (sp_r == SPW'(STACK_DEPTH));
    gcnt_x = (XW'(gcfg_r) < XW'(GLOBAL_DEPTH)) ? XW'(gcfg_r) : XW'(GLOBAL_DEPTH);
    g_bad  = neg || (opnd_x >= gcnt_x);
    pos_x  = fp_x + opnd_x;
    is_div = (ir_r.mode == MODE_DIV) || (ir_r.mode == MODE_MOD);
    case (ir_r.mode)
      MODE_ADD: alu = rd0_r + rd1_r;
      MODE_SUB: alu = rd0_r - rd1_r;
      MODE_MUL: alu = rd0_r * rd1_r;
      default:  alu = '0;
    endcase
    if (ir_r.mode == MODE_DIV) begin
      res = div_q;
    end else if (ir_r.mode == MODE_MOD) begin
      res = div_r;
    end else begin
      res = alu;
    end

    ex_status = STAT_DONE;
    ex_kind   = KIND_NONE;
    ex_wval   = '0;
    ex_sp     = sp_r;
    ex_fp     = fp_r;
    ex_st_we  = 1'b0;
    ex_g_we   = 1'b0;
    st_wa_x   = sp_x;
    st_wd     = ir_r.imm;
    want_div  = 1'b0;
    unique case (ir_r.cls)
      CLS_PUSHV: begin
        if (full) begin
          ex_status = STAT_OVFL;
        end else begin
          ex_st_we = 1'b1;
          ex_sp    = SPW'(sp_x + XW'(1));
        end
      end
      CLS_ARITH: begin
        if (sp_r < SPW'(2)) begin
          ex_status = STAT_SKIP;
        end else if (is_div && (rd1_r == '0)) begin
          ex_status = STAT_SKIP;
        end else if (is_div && (state_r == BS_EXEC)) begin
          want_div = 1'b1;
        end else begin
          ex_st_we = 1'b1;
          st_wa_x  = sp_x - XW'(2);
          st_wd    = res;
          ex_sp    = SPW'(sp_x - XW'(1));
        end
      end
      CLS_WRITE: begin
        if (sp_r == '0) begin
          ex_status = STAT_SKIP;
        end else begin
          if (ir_r.mode == MODE_WRCHR) begin
            ex_kind = KIND_CHR;
            ex_wval = {24'd0, rd1_r[7:0]};
          end else begin
            ex_kind = KIND_INT;
            ex_wval = rd1_r;
          end
          ex_sp = SPW'(sp_x - XW'(1));
        end
      end
      CLS_PUSHG: begin
        if (g_bad) begin
          ex_status = STAT_SKIP;
        end else if (full) begin
          ex_status = STAT_OVFL;
        end else begin
          ex_st_we = 1'b1;
          st_wd    = gd_r;
          ex_sp    = SPW'(sp_x + XW'(1));
        end
      end
      CLS_POPG: begin
        if (g_bad || (sp_r == '0)) begin
          ex_status = STAT_SKIP;
        end else begin
          ex_g_we = 1'b1;
          ex_sp   = SPW'(sp_x - XW'(1));
        end
      end
      CLS_ASF: begin
        if (neg) begin
          ex_status = STAT_SKIP;
        end else if (full || ((sp_x + XW'(1) + opnd_x) > XW'(STACK_DEPTH))) begin
          ex_status = STAT_OVFL;
        end else begin
          ex_st_we = 1'b1;
          st_wd    = 32'(fp_r);
          ex_fp    = SPW'(sp_x + XW'(1));
          ex_sp    = SPW'(sp_x + XW'(1) + opnd_x);
        end
      end
      CLS_RSF: begin
        if ((fp_r == '0) || (rd0_r >= 32'(fp_r))) begin
          ex_status = STAT_SKIP;
        end else begin
          ex_sp = SPW'(fp_x - XW'(1));
          ex_fp = rd0_r[SPW-1:0];
        end
      end
      CLS_PUSHL: begin
        if (neg || (pos_x >= sp_x)) begin
          ex_status = STAT_SKIP;
        end else if (full) begin
          ex_status = STAT_OVFL;
        end else begin
          ex_st_we = 1'b1;
          st_wd    = rd0_r;
          ex_sp    = SPW'(sp_x + XW'(1));
        end
      end
      CLS_POPL: begin
        if (neg || (sp_r <= fp_r) || (pos_x >= sp_x)) begin
          ex_status = STAT_SKIP;
        end else begin
          ex_st_we = 1'b1;
          st_wa_x  = pos_x;
          st_wd    = rd1_r;
          ex_sp    = SPW'(sp_x - XW'(1));
        end
      end
      default: begin
        ex_status = STAT_SKIP;
      end
    endcase
  end

  // An instruction retires once its result has somewhere to go.
  assign div_start = (state_r == BS_EXEC) && want_div;
  assign commit    = (((state_r == BS_EXEC) && !want_div) ||
                      ((state_r == BS_DIV) && !div_busy)) && out_free;

  // Sequencer and clearing pass.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      BS_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(MAXD - 1)) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (take) begin
          state_nxt = BS_EXEC;
        end
      end
      BS_EXEC: begin
        if (want_div) begin
          state_nxt = BS_DIV;
        end else if (commit) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_DIV: begin
        if (commit) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_CLEAR;
    endcase
    sp_nxt = commit ? ex_sp : sp_r;
    fp_nxt = commit ? ex_fp : fp_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      fp_r        <= '0;
      gcfg_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      fp_r        <= fp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        gcfg_r <= cfg_wr_data;
      end
    end
  end

  // Memory write ports, shared by the clearing pass and retirement.
  always_comb begin
    clr_st = clearing && ({1'b0, clr_r} < (CW+1)'(STACK_DEPTH));
    clr_g  = clearing && ({1'b0, clr_r} < (CW+1)'(GLOBAL_DEPTH));
    st_we  = clr_st || (commit && ex_st_we);
    g_we   = clr_g || (commit && ex_g_we);
    st_wa  = clearing ? clr_r[AW-1:0] : st_wa_x[AW-1:0];
    g_wa   = clearing ? GAW'(clr_r) : ir_r.opnd[GAW-1:0];
    g_wd   = clearing ? 32'd0 : rd1_r;
  end

  // Operand stack memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (st_we) begin
      stk_mem[st_wa] <= clearing ? 32'd0 : st_wd;
    end
    if (take) begin
      rd0_r <= stk_mem[ra0_x[AW-1:0]];
      rd1_r <= stk_mem[ra1_x[AW-1:0]];
    end
  end

  // Global data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (g_we) begin
      glb_mem[g_wa] <= g_wd;
    end
    if (take) begin
      gd_r <= glb_mem[q_data.opnd[GAW-1:0]];
    end
  end

  // Instruction register and result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      ir_r <= q_data;
    end
    if (commit) begin
      status_r <= ex_status;
      kind_r   <= ex_kind;
      wval_r   <= ex_wval;
      lvl_r    <= ex_sp;
      fb_r     <= ex_fp;
    end
  end

  smeu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd0_r),
    .divisor  (rd1_r),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_write_kind  = kind_r;
  assign out_write_value = wval_r;
  assign out_stack_level = lvl_r;
  assign out_frame_base  = fb_r;

  // Pointer bounds, clearing quiet, retirement and divider handshakes.
  `SMEU_ASSERT_IMP(a_sp_bound, 1'b1, sp_r <= SPW'(STACK_DEPTH), "stack pointer past depth")
  `SMEU_ASSERT_IMP(a_fp_bound, 1'b1, fp_r <= SPW'(STACK_DEPTH), "frame pointer past depth")
  `SMEU_ASSERT_IMP(a_clear_quiet, state_r == BS_CLEAR, !out_valid_r, "result during clear")
  `SMEU_ASSERT_NXT(a_commit_out, commit, out_valid_r, "retired result not presented")
  `SMEU_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divider restarted while busy")

endmodule

FILE: rtl/core/stack_machine_execute_unit.sv
// Stack machine execute unit: one instruction per input transaction, one
// result transaction per instruction. In the back end an ordinary instruction
// first reads up to two operand stack entries and one global entry through
// the registered memory read ports, then executes and writes back; a short
// queue lets the front end keep accepting meanwhile. div and mod with a
// nonzero divisor also wait for the iterative one-bit-per-cycle divider.
// After reset a clearing pass zeroes both memories, during which no
// instruction is accepted; cfg_wr_en writes global_count at any time.
// Depends on smeu_pkg, smeu_front, smeu_queue and smeu_back.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH  = 256,
  parameter int GLOBAL_DEPTH = 64,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic signed [23:0] in_operand,
  input  logic signed [31:0] in_read_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [1:0]         out_write_kind,
  output logic signed [31:0] out_write_value,
  output logic [SPW-1:0]     out_stack_level,
  output logic [SPW-1:0]     out_frame_base,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  logic   clearing;
  logic   push_valid, push_stall, pop_valid, pop_stall;
  instr_t push_data, pop_data;

  smeu_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_operand    (in_operand),
    .in_read_value (in_read_value),
    .clearing      (clearing),
    .q_push_valid  (push_valid),
    .q_push_stall  (push_stall),
    .q_push_data   (push_data)
  );

  smeu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  smeu_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .GLOBAL_DEPTH (GLOBAL_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_stall         (pop_stall),
    .q_data          (pop_data),
    .clearing        (clearing),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_write_kind  (out_write_kind),
    .out_write_value (out_write_value),
    .out_stack_level (out_stack_level),
    .out_frame_base  (out_frame_base)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for stack_machine_execute_unit.
// It sends directed and random instructions, predicts each result from its model
// of the stack, frame and global area or the directed table, and checks every result.
// Depends on smeu_pkg and the RTL of the execute unit.
module testbench;
  import smeu_pkg::*;

  localparam int DEPTH      = 256;
  localparam int GLOBALS    = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 50;
  localparam int PHASES     = 6;

  typedef struct packed {
    stat_t       status;
    kind_t       kind;
    logic [31:0] value;
    logic [8:0]  level;
    logic [8:0]  base;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    logic [23:0] operand;
    logic [31:0] read_value;
    logic        typed;
    result_t     res;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_mode;
  logic signed [23:0] in_operand;
  logic signed [31:0] in_read_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [1:0]         out_write_kind;
  logic signed [31:0] out_write_value;
  logic [8:0]         out_stack_level;
  logic [8:0]         out_frame_base;
  logic               cfg_wr_en;
  logic [6:0]         cfg_wr_data;

  // Model state, kept in step with the accepted transactions.
  logic [31:0] stack_mem [DEPTH];
  logic [31:0] global_mem [GLOBALS];
  int          stack_ptr;
  int          frame_ptr;
  int          global_count;

  result_t     pending_results [$];
  int          in_count;
  int          out_count;
  int          errors;
  int          idle_cycles;
  logic        drv_typed;
  result_t     drv_result;
  row_t        rows [26];

  stack_machine_execute_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_operand     (in_operand),
    .in_read_value  (in_read_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_write_kind (out_write_kind),
    .out_write_value(out_write_value),
    .out_stack_level(out_stack_level),
    .out_frame_base (out_frame_base),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Executes one instruction on the model state and returns its result.
  function automatic result_t exec_instr(mode_t m, logic signed [23:0] op,
                                         logic [31:0] rv);
    longint      opnd;
    longint      pos;
    longint      x;
    longint      y;
    longint      q;
    int          sp;
    int          fp;
    int          gcnt;
    bit          full;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    result_t     r;
    opnd = op;
    sp = stack_ptr;
    fp = frame_ptr;
    full = (sp >= DEPTH);
    gcnt = (global_count < GLOBALS) ? global_count : GLOBALS;
    a = '0;
    b = '0;
    r.status = STAT_DONE;
    r.kind = KIND_NONE;
    r.value = '0;
    if (sp >= 2) begin
      a = stack_mem[sp-2];
      b = stack_mem[sp-1];
    end
    case (m)
      MODE_PUSHC, MODE_RDINT, MODE_RDCHR: begin
        if (m == MODE_PUSHC) v = {{8{op[23]}}, op};
        else if (m == MODE_RDINT) v = rv;
        else v = {{24{rv[7]}}, rv[7:0]};
        if (full) begin
          r.status = STAT_OVFL;
        end else begin
          stack_mem[sp] = v;
          stack_ptr = sp + 1;
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
        if (sp < 2) begin
          r.status = STAT_SKIP;
        end else begin
          x = $signed(a);
          y = $signed(b);
          case (m)
            MODE_ADD: v = a + b;
            MODE_SUB: v = a - b;
            MODE_MUL: v = a * b;
            default: begin
              if (y == 0) begin
                r.status = STAT_SKIP;
              end else begin
                q = (m == MODE_DIV) ? x / y : x % y;
                v = q[31:0];
              end
            end
          endcase
          if (r.status == STAT_DONE) begin
            stack_mem[sp-2] = v;
            stack_ptr = sp - 1;
          end
        end
      end
      MODE_WRINT, MODE_WRCHR: begin
        if (sp < 1) begin
          r.status = STAT_SKIP;
        end else begin
          r.value = stack_mem[sp-1];
          if (m == MODE_WRCHR) begin
            r.value = {24'd0, r.value[7:0]};
            r.kind = KIND_CHR;
          end else begin
            r.kind = KIND_INT;
          end
          stack_ptr = sp - 1;
        end
      end
      MODE_PUSHG: begin
        if (opnd < 0 || opnd >= gcnt) begin
          r.status = STAT_SKIP;
        end else if (full) begin
          r.status = STAT_OVFL;
        end else begin
          stack_mem[sp] = global_mem[opnd];
          stack_ptr = sp + 1;
        end
      end
      MODE_POPG: begin
        if (opnd < 0 || opnd >= gcnt || sp < 1) begin
          r.status = STAT_SKIP;
        end else begin
          global_mem[opnd] = stack_mem[sp-1];
          stack_ptr = sp - 1;
        end
      end
      MODE_ASF: begin
        if (opnd < 0) begin
          r.status = STAT_SKIP;
        end else if (full || sp + 1 + opnd > DEPTH) begin
          r.status = STAT_OVFL;
        end else begin
          stack_mem[sp] = fp;
          frame_ptr = sp + 1;
          stack_ptr = sp + 1 + int'(opnd);
        end
      end
      MODE_RSF: begin
        if (fp == 0 || stack_mem[fp-1] >= fp) begin
          r.status = STAT_SKIP;
        end else begin
          stack_ptr = fp - 1;
          frame_ptr = stack_mem[fp-1];
        end
      end
      MODE_PUSHL: begin
        pos = fp + opnd;
        if (opnd < 0 || pos >= sp) begin
          r.status = STAT_SKIP;
        end else if (full) begin
          r.status = STAT_OVFL;
        end else begin
          stack_mem[sp] = stack_mem[pos];
          stack_ptr = sp + 1;
        end
      end
      default: begin
        pos = fp + opnd;
        if (opnd < 0 || sp <= fp || pos >= sp) begin
          r.status = STAT_SKIP;
        end else begin
          stack_mem[pos] = stack_mem[sp-1];
          stack_ptr = sp - 1;
        end
      end
    endcase
    r.level = stack_ptr[8:0];
    r.base = frame_ptr[8:0];
    return r;
  endfunction

  // Input transactions: predict the result and queue it.
  always @(posedge clk) begin
    result_t r;
    if (rst_n && in_valid && !in_stall) begin
      r = exec_instr(mode_t'(in_mode), in_operand, in_read_value);
      pending_results.push_back(drv_typed ? drv_result : r);
      in_count <= in_count + 1;
    end
  end

  // Result transactions: compare with the oldest expected result.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      out_count <= out_count + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d level %0d", out_status, out_stack_level);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status != e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          errors++;
        end
        if (out_write_kind != e.kind) begin
          $error("write_kind: expected %0d, actual %0d", e.kind, out_write_kind);
          errors++;
        end
        if (out_write_value != e.value) begin
          $error("write_value: expected %0h, actual %0h", e.value, out_write_value);
          errors++;
        end
        if (out_stack_level != e.level) begin
          $error("stack_level: expected %0d, actual %0d", e.level, out_stack_level);
          errors++;
        end
        if (out_frame_base != e.base) begin
          $error("frame_base: expected %0d, actual %0d", e.base, out_frame_base);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Receiver stalls a random number of cycles before each result.
  initial begin
    int n;
    int seen;
    out_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      repeat (n) @(negedge clk) out_stall = 1'b1;
      @(negedge clk) out_stall = 1'b0;
      seen = out_count;
      while (out_count == seen) @(negedge clk);
    end
  end

  // Drives one instruction after a random gap, or none with no_gaps, and waits for its acceptance.
  // The task is entered and left at a falling edge; valid drops as soon as
  // the transaction has been taken, so it is never accepted twice.
  task automatic send_instr(mode_t m, logic [23:0] op, logic [31:0] rv,
                            logic typed, result_t r, bit no_gaps);
    int gap;
    int seen;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk) in_valid = 1'b0;
    in_valid = 1'b1;
    in_mode = m;
    in_operand = op;
    in_read_value = rv;
    drv_typed = typed;
    drv_result = r;
    seen = in_count;
    while (in_count == seen) @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits for every expected result, lets a slow divide finish, and sets the
  // global count.
  task automatic set_global_count(logic [6:0] value);
    @(negedge clk) in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    global_count = int'(value);
    @(negedge clk) cfg_wr_en = 1'b0;
  endtask

  // Main sequence: reset, directed table, then random phases.
  initial begin
    int            counts [PHASES];
    int            push_weight [PHASES];
    logic [6:0]    gcounts [PHASES];
    int            sel;
    int            span;
    logic [23:0]   op;
    mode_t         m;
    bit            no_gaps;
    result_t       none;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_operand = '0;
    in_read_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    drv_typed = 1'b0;
    drv_result = '0;
    none = '0;
    in_count = 0;
    out_count = 0;
    errors = 0;
    idle_cycles = 0;
    for (int i = 0; i < DEPTH; i++) stack_mem[i] = '0;
    for (int i = 0; i < GLOBALS; i++) global_mem[i] = '0;
    stack_ptr = 0;
    frame_ptr = 0;
    global_count = 0;
    counts = '{150, 150, 300, 150, 150, 150};
    push_weight = '{40, 50, 95, 30, 50, 45};
    gcounts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd33, 7'd100};

    // Guards on an empty stack, the field extremes, the division corner cases,
    // frames and console writes.
    rows = '{
      '{MODE_ADD,   24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_WRINT, 24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_POPG,  24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_RSF,   24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_PUSHG, 24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_PUSHL, 24'd0,      32'd0,   1'b1, '{STAT_SKIP, KIND_NONE, 32'd0, 9'd0, 9'd0}},
      '{MODE_PUSHC, 24'h7fffff, 32'd0,   1'b1, '{STAT_DONE, KIND_NONE, 32'd0, 9'd1, 9'd0}},
      '{MODE_PUSHC, 24'h800000, 32'd0,   1'b1, '{STAT_DONE, KIND_NONE, 32'd0, 9'd2, 9'd0}},
      '{MODE_MUL,   24'd0,      32'd0,   1'b0, none},
      '{MODE_RDINT, 24'd0, 32'h80000000, 1'b0, none},
      '{MODE_PUSHC, 24'hffffff, 32'd0,   1'b0, none},
      '{MODE_DIV,   24'd0,      32'd0,   1'b0, none},
      '{MODE_RDINT, 24'd0, 32'h80000000, 1'b0, none},
      '{MODE_PUSHC, 24'hffffff, 32'd0,   1'b0, none},
      '{MODE_MOD,   24'd0,      32'd0,   1'b0, none},
      '{MODE_PUSHC, 24'd0,      32'd0,   1'b0, none},
      '{MODE_DIV,   24'd0,      32'd0,   1'b0, none},
      '{MODE_MOD,   24'd0,      32'd0,   1'b0, none},
      '{MODE_RDCHR, 24'd0, 32'hffffffff, 1'b0, none},
      '{MODE_WRCHR, 24'd0,      32'd0,   1'b0, none},
      '{MODE_ASF,   24'd3,      32'd0,   1'b0, none},
      '{MODE_POPL,  24'd0,      32'd0,   1'b0, none},
      '{MODE_PUSHL, 24'hffffff, 32'd0,   1'b0, none},
      '{MODE_RSF,   24'd0,      32'd0,   1'b0, none},
      '{MODE_ASF,   24'h800000, 32'd0,   1'b0, none},
      '{MODE_WRINT, 24'd0,      32'd0,   1'b0, none}
    };

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) begin
      send_instr(rows[i].mode, rows[i].operand, rows[i].read_value, rows[i].typed,
                 rows[i].res, 1'b0);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_global_count(gcounts[p]);
      for (int k = 0; k < counts[p]; k++) begin
        // Stretches without gaps, every fourth block of 25 items.
        no_gaps = ((k / 25) % 4 == 3);
        if ($urandom_range(0, 99) < push_weight[p]) begin
          sel = $urandom_range(0, 5);
          case (sel)
            0: m = MODE_PUSHC;
            1: m = MODE_RDINT;
            2: m = MODE_RDCHR;
            3: m = MODE_PUSHG;
            4: m = MODE_PUSHL;
            default: m = MODE_ASF;
          endcase
        end else begin
          m = mode_t'($urandom_range(0, 15));
        end
        // Mostly meaningful operands, with full-range noise mixed in.
        op = 24'($urandom());
        if ($urandom_range(0, 7) != 0) begin
          case (m)
            MODE_PUSHC: if ($urandom_range(0, 3) == 0) op = 24'($signed($urandom_range(0, 4)) - 2);
            MODE_PUSHG, MODE_POPG: op = 24'($urandom_range(0, 65));
            MODE_ASF: op = 24'($urandom_range(0, 4));
            MODE_PUSHL, MODE_POPL: begin
              span = (stack_ptr > frame_ptr) ? stack_ptr - frame_ptr : 2;
              op = 24'($urandom_range(0, span));
            end
            default: ;
          endcase
        end
        send_instr(m, op, $urandom(), 1'b0, none, no_gaps);
      end
    end

    @(negedge clk) in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: stack_machine_execute_unit.f
+incdir+rtl/core
rtl/core/smeu_pkg.sv
rtl/core/smeu_div.sv
rtl/core/smeu_queue.sv
rtl/core/smeu_front.sv
rtl/core/smeu_back.sv
rtl/core/stack_machine_execute_unit.sv
test/testbench.sv
